/* sv/ttcg_pkg.sv */
// shared types and constants for the tone table color gain block
// no dependencies
package ttcg_pkg;

	localparam int unsigned TT_AW     = 16;
	localparam int unsigned TT_DEPTH  = 1 << TT_AW;
	localparam int unsigned Q_DEPTH   = 4;
	localparam int unsigned Q_PW      = $clog2(Q_DEPTH);
	localparam int unsigned DIV_STEPS = 12;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	localparam logic [3:0] GAIN_RESET = 4'd4;

	// one classified transaction between front and back
	typedef struct packed {
		logic        is_pix;
		logic [15:0] waddr;
		logic [7:0]  wdata;
		logic [7:0]  luma;
		logic [7:0]  bs;
		logic [7:0]  bm;
		logic [7:0]  bl;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
	} ttcg_item_t;

endpackage

/* sv/ttcg_front.sv */
// front end: accepts input transactions and classifies them
// depends on ttcg_pkg
module ttcg_front import ttcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [15:0] table_index,
	input  logic [7:0]  table_value,
	input  logic [7:0]  luma,
	input  logic [7:0]  blur_small,
	input  logic [7:0]  blur_medium,
	input  logic [7:0]  blur_large,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	output logic        fr_valid,
	input  logic        fr_ready,
	output ttcg_item_t  fr_item
);

	logic       valid_s1;
	ttcg_item_t item_s1;

	assign in_ready = !valid_s1 || fr_ready;
	assign fr_valid = valid_s1;
	assign fr_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.is_pix <= (kind == KIND_PIXEL);
			item_s1.waddr  <= table_index;
			item_s1.wdata  <= table_value;
			item_s1.luma   <= luma;
			item_s1.bs     <= blur_small;
			item_s1.bm     <= blur_medium;
			item_s1.bl     <= blur_large;
			item_s1.blue   <= blue;
			item_s1.green  <= green;
			item_s1.red    <= red;
		end
	end

endmodule

/* sv/ttcg_queue.sv */
// short fifo between front and back
// depends on ttcg_pkg
module ttcg_queue import ttcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  ttcg_item_t push_item,
	output logic       pop_valid,
	input  logic       pop_ready,
	output ttcg_item_t pop_item
);

	ttcg_item_t       slot_q [0:Q_DEPTH-1];
	logic [Q_PW-1:0]  wr_q;
	logic [Q_PW-1:0]  rd_q;
	logic [Q_PW:0]    cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != (Q_PW+1)'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (Q_PW+1)'(push) - (Q_PW+1)'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("queue pop while empty");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + (Q_PW+1)'($past(push)) - (Q_PW+1)'($past(pop)))
		else $error("queue count mismatch");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != (Q_PW+1)'(Q_DEPTH) && cnt_q != '0 |-> wr_q != rd_q)
		else $error("queue pointers disagree with count");
`endif

endmodule

/* sv/ttcg_back.sv */
// back end: tone table storage, gain computation, pipelined divider, output register
// depends on ttcg_pkg
module ttcg_back import ttcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  gain_limit,
	input  logic        q_valid,
	output logic        q_ready,
	input  ttcg_item_t  q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red
);

	typedef struct packed {
		logic [9:0]  rem;
		logic [11:0] rest;
		logic [11:0] quo;
	} dv_t;

	function automatic dv_t div_step(dv_t a, logic [9:0] den);
		logic [10:0] t;
		dv_t         r;
		t      = {a.rem, a.rest[11]};
		r.rest = {a.rest[10:0], 1'b0};
		if (t >= {1'b0, den}) begin
			r.rem = 10'(t - {1'b0, den});
			r.quo = {a.quo[10:0], 1'b1};
		end else begin
			r.rem = t[9:0];
			r.quo = {a.quo[10:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [7:0] sat12(logic [11:0] v);
		return (v > 12'd255) ? 8'd255 : v[7:0];
	endfunction

	logic adv;
	logic pop;

	// three copies so every pixel gets its three lookups in the same cycle
	logic [7:0] tta_mem [0:TT_DEPTH-1];
	logic [7:0] ttb_mem [0:TT_DEPTH-1];
	logic [7:0] ttc_mem [0:TT_DEPTH-1];

	logic       v_s1;
	logic [7:0] ta_s1, tb_s1, tc_s1, luma_s1;
	logic [7:0] ch_s1 [0:2];

	logic        v_s2;
	logic [9:0]  ssum_s2;
	logic [13:0] lim_s2;
	logic [7:0]  luma_s2;
	logic [7:0]  ch_s2 [0:2];

	logic        v_s3;
	logic        cap_s3;
	logic [9:0]  den_s3;
	logic [17:0] num_s3  [0:2];
	logic [11:0] capv_s3 [0:2];

	logic        dvv_q   [0:DIV_STEPS];
	logic        dcap_q  [0:DIV_STEPS];
	logic [9:0]  dden_q  [0:DIV_STEPS];
	dv_t         dv_q    [0:DIV_STEPS][0:2];
	logic [11:0] dcapv_q [0:DIV_STEPS][0:2];

	logic       out_valid_q;
	logic [7:0] res_q [0:2];
	logic [7:0] res_d [0:2];

	assign adv       = !out_valid_q || out_ready;
	assign q_ready   = adv;
	assign pop       = adv && q_valid;
	assign out_valid = out_valid_q;
	assign out_blue  = res_q[0];
	assign out_green = res_q[1];
	assign out_red   = res_q[2];

	always_ff @(posedge clk) begin
		if (pop && !q_item.is_pix) begin
			tta_mem[q_item.waddr] <= q_item.wdata;
			ttb_mem[q_item.waddr] <= q_item.wdata;
			ttc_mem[q_item.waddr] <= q_item.wdata;
		end
	end

	always_comb begin
		logic [12:0] qr;
		logic [10:0] r2;
		logic        up;
		for (int c = 0; c < 3; c++) begin
			r2 = {dv_q[DIV_STEPS][c].rem, 1'b0};
			up = (r2 > {1'b0, dden_q[DIV_STEPS]}) ||
			     ((r2 == {1'b0, dden_q[DIV_STEPS]}) && dv_q[DIV_STEPS][c].quo[0]);
			qr = {1'b0, dv_q[DIV_STEPS][c].quo} + 13'(up);
			if (dcap_q[DIV_STEPS]) begin
				res_d[c] = sat12(dcapv_q[DIV_STEPS][c]);
			end else begin
				res_d[c] = (qr > 13'd255) ? 8'd255 : qr[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) dvv_q[k] <= 1'b0;
		end else if (adv) begin
			v_s1     <= pop && q_item.is_pix;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			dvv_q[0] <= v_s3;
			for (int k = 0; k < DIV_STEPS; k++) dvv_q[k+1] <= dvv_q[k];
			out_valid_q <= dvv_q[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// table lookup
			ta_s1    <= tta_mem[{q_item.bs, q_item.luma}];
			tb_s1    <= ttb_mem[{q_item.bm, q_item.luma}];
			tc_s1    <= ttc_mem[{q_item.bl, q_item.luma}];
			luma_s1  <= q_item.luma;
			ch_s1[0] <= q_item.blue;
			ch_s1[1] <= q_item.green;
			ch_s1[2] <= q_item.red;
			// sum and gain threshold
			ssum_s2  <= 10'(ta_s1) + 10'(tb_s1) + 10'(tc_s1);
			lim_s2   <= 14'(gain_limit) * 14'(luma_s1) * 14'd3;
			luma_s2  <= luma_s1;
			ch_s2    <= ch_s1;
			// branch choice and products
			cap_s3   <= {4'b0, ssum_s2} >= lim_s2;
			den_s3   <= 10'(luma_s2) + {1'b0, luma_s2, 1'b0};
			for (int c = 0; c < 3; c++) begin
				num_s3[c]  <= 18'(ch_s2[c]) * 18'(ssum_s2);
				capv_s3[c] <= 12'(gain_limit) * 12'(ch_s2[c]);
			end
			// divider pipeline, one quotient bit per stage
			dcap_q[0] <= cap_s3;
			dden_q[0] <= den_s3;
			for (int c = 0; c < 3; c++) begin
				dv_q[0][c].rem  <= {4'b0, num_s3[c][17:12]};
				dv_q[0][c].rest <= num_s3[c][11:0];
				dv_q[0][c].quo  <= '0;
				dcapv_q[0][c]   <= capv_s3[c];
			end
			for (int k = 0; k < DIV_STEPS; k++) begin
				dcap_q[k+1] <= dcap_q[k];
				dden_q[k+1] <= dden_q[k];
				for (int c = 0; c < 3; c++) begin
					dv_q[k+1][c]    <= div_step(dv_q[k][c], dden_q[k]);
					dcapv_q[k+1][c] <= dcapv_q[k][c];
				end
			end
			res_q <= res_d;
		end
	end

endmodule

/* sv/tone_table_color_gain_apply.sv */
// top level of the tone table color gain block
// depends on ttcg_pkg, ttcg_front, ttcg_queue, ttcg_back
//
// takes one transaction per clock, sustained, whenever the output side keeps up.
// a kind 0 transaction writes one byte of the 64k tone table (addressed by blurred
// luma times 256 plus luma) and gives no result; a kind 1 transaction is a pixel
// whose three table bytes set the gain applied to blue, green and red. the table
// is held in three identical 64k x 8 memories, each written by every table write,
// so the three lookups of a pixel happen in the same cycle. the table is not
// cleared by reset and needs no clearing pass; software fills every entry it will
// use before sending pixels. a pixel result passes through one front register,
// the fifo, lookup, sum, products, a restoring divider of one load stage and 12
// steps (one quotient bit per step), and the output register. the whole back
// pipeline stalls as one while out_valid is high and out_ready is low; the
// 4-entry fifo lets the front keep accepting meanwhile until it is full.
// gain_limit resets to 4 and may be written only while the block is idle.
module tone_table_color_gain_apply import ttcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [15:0] table_index,
	input  logic [7:0]  table_value,
	input  logic [7:0]  luma,
	input  logic [7:0]  blur_small,
	input  logic [7:0]  blur_medium,
	input  logic [7:0]  blur_large,
	input  logic [7:0]  blue,
	input  logic [7:0]  green,
	input  logic [7:0]  red,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red
);

	logic       cfg_take;
	logic [3:0] gain_limit_q;
	logic       fr_valid;
	logic       fr_ready;
	ttcg_item_t fr_item;
	logic       q_valid;
	logic       q_ready;
	ttcg_item_t q_item;

	// config write is always taken
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_limit_q <= GAIN_RESET;
		end else if (cfg_take) begin
			gain_limit_q <= cfg_data;
		end
	end

	// accept and classify
	ttcg_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .kind, .table_index, .table_value,
		.luma, .blur_small, .blur_medium, .blur_large, .blue, .green, .red,
		.fr_valid, .fr_ready, .fr_item
	);

	// decouples front from back stalls
	ttcg_queue u_queue (
		.clk, .arst_n,
		.push_valid (fr_valid), .push_ready (fr_ready), .push_item (fr_item),
		.pop_valid  (q_valid),  .pop_ready  (q_ready),  .pop_item  (q_item)
	);

	// table, gain math, output register
	ttcg_back u_back (
		.clk, .arst_n, .gain_limit (gain_limit_q),
		.q_valid, .q_ready, .q_item,
		.out_valid, .out_ready, .out_blue, .out_green, .out_red
	);

endmodule
